// ----- rtl/ethernet_header_classifier_defines.svh -----
// -----------------------------------------------------------------------------
// Ethernet header classifier assertion macros
// Concurrent assertion wrappers shared by the classifier RTL.
// -----------------------------------------------------------------------------
`ifndef ETHERNET_HEADER_CLASSIFIER_DEFINES_SVH
`define ETHERNET_HEADER_CLASSIFIER_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every rising clock edge outside of reset.
`define EHC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising clock edge, reset included.
`define EHC_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define EHC_ASSERT(label, clk, rst, prop, msg)
`define EHC_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// ----- rtl/ehc_pkg.sv -----
// -----------------------------------------------------------------------------
// Ethernet header classifier package
// Constants, class codes and frame record types shared by the classifier.
// -----------------------------------------------------------------------------
`default_nettype none

package ehc_pkg;

   localparam logic [15:0] ETH_HDR_LEN    = 16'd14;
   localparam logic [15:0] ARP_MIN_LEN    = 16'd42;
   localparam logic [15:0] TYPE_IPV4      = 16'h0800;
   localparam logic [15:0] TYPE_ARP       = 16'h0806;
   localparam logic [15:0] WEB_PORT_RESET = 16'd80;
   localparam logic [15:0] OFFSET_MAX     = 16'hFFFF;
   localparam logic [7:0]  PROTO_ICMP     = 8'd1;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   typedef enum logic [3:0] {
      CLASS_MALFORMED = 4'd0,
      CLASS_UNKNOWN   = 4'd1,
      CLASS_IPV4      = 4'd2,
      CLASS_TCP       = 4'd3,
      CLASS_HTTP      = 4'd4,
      CLASS_UDP       = 4'd5,
      CLASS_ICMP      = 4'd6,
      CLASS_ARP       = 4'd7,
      CLASS_ARP_SHORT = 4'd8
   } ehc_class_type;

   // Per-frame capture state.
   typedef struct packed {
      logic [15:0] byte_offset;
      logic [15:0] ether_kind;
      logic [3:0]  ip_header_words;
      logic [7:0]  ip_protocol;
      logic [47:0] dest_mac;
      logic [47:0] source_mac;
      logic [31:0] source_ip;
      logic [31:0] dest_ip;
      logic [15:0] source_port;
      logic [15:0] dest_port;
      logic [7:0]  flags;
      logic [15:0] sub_type;
   } ehc_frame_type;

   // Handoff from the capture stage to the result stage. On a frame's last
   // beat, frame.byte_offset holds the saturated frame length.
   typedef struct packed {
      logic          load;
      ehc_frame_type frame;
   } ehc_done_type;

   typedef struct packed {
      ehc_class_type frame_class;
      logic [15:0]   frame_length;
      logic [47:0]   dest_mac;
      logic [47:0]   source_mac;
      logic [31:0]   source_ip;
      logic [31:0]   dest_ip;
      logic [15:0]   source_port;
      logic [15:0]   dest_port;
      logic [7:0]    tcp_flag_bits;
      logic [15:0]   sub_type;
   } ehc_result_type;

endpackage

`default_nettype wire

// ----- rtl/ehc_if.sv -----
// -----------------------------------------------------------------------------
// Ethernet header classifier channels
// Valid/ready interfaces for the byte input, the summary output and the CSR.
// -----------------------------------------------------------------------------
`default_nettype none

interface ehc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ehc_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  frame_class;
   logic [15:0] frame_length;
   logic [47:0] dest_mac;
   logic [47:0] source_mac;
   logic [31:0] source_ip;
   logic [31:0] dest_ip;
   logic [15:0] source_port;
   logic [15:0] dest_port;
   logic [7:0]  tcp_flag_bits;
   logic [15:0] sub_type;

   modport source (
      output valid, output frame_class, output frame_length, output dest_mac,
      output source_mac, output source_ip, output dest_ip, output source_port,
      output dest_port, output tcp_flag_bits, output sub_type, input ready
   );
   modport sink (
      input valid, input frame_class, input frame_length, input dest_mac,
      input source_mac, input source_ip, input dest_ip, input source_port,
      input dest_port, input tcp_flag_bits, input sub_type, output ready
   );
endinterface

interface ehc_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] web_port;

   modport source (output valid, output web_port, input ready);
   modport sink   (input valid, input web_port, output ready);
endinterface

`default_nettype wire

// ----- rtl/ehc_capture.sv -----
// -----------------------------------------------------------------------------
// Ethernet header classifier capture stage
// Input beat register, byte offset counter and header field capture.
// -----------------------------------------------------------------------------
`default_nettype none

`include "ethernet_header_classifier_defines.svh"

module ehc_capture
   import ehc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   ehc_req_if.sink       req_bus,
   input  logic          rsp_free,
   output ehc_done_type  done
);

   logic          s1_valid_ff, s1_valid_in;
   logic [7:0]    s1_byte_ff;
   logic          s1_last_ff;
   ehc_frame_type frame_ff, frame_in;
   ehc_frame_type cap;
   logic          accept;
   logic          advance;
   logic [15:0]   off;
   logic [7:0]    b;
   logic [3:0]    words;
   logic [6:0]    trans;
   logic [15:0]   rel;

   // A last beat can only move on when the result register has room.
   assign advance       = s1_valid_ff && (!s1_last_ff || rsp_free);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_byte_ff <= req_bus.data_byte;
         s1_last_ff <= req_bus.last_byte;
      end
   end

   always_comb begin
      cap   = frame_ff;
      off   = frame_ff.byte_offset;
      b     = s1_byte_ff;
      words = frame_ff.ip_header_words;
      trans = 7'd0;
      rel   = 16'd0;
      if (off < 16'd6) begin
         cap.dest_mac = {frame_ff.dest_mac[39:0], b};
      end else if (off < 16'd12) begin
         cap.source_mac = {frame_ff.source_mac[39:0], b};
      end else if (off < ETH_HDR_LEN) begin
         cap.ether_kind = {frame_ff.ether_kind[7:0], b};
      end else if (frame_ff.ether_kind == TYPE_IPV4) begin
         if (off == ETH_HDR_LEN) begin
            words               = b[3:0];
            cap.ip_header_words = b[3:0];
         end
         // The transport header starts right after the IP header.
         trans = ETH_HDR_LEN[6:0] + {1'b0, words, 2'b00};
         if (off == 16'd23) begin
            cap.ip_protocol = b;
         end
         if (off >= 16'd26 && off < 16'd30) begin
            cap.source_ip = {frame_ff.source_ip[23:0], b};
         end
         if (off >= 16'd30 && off < 16'd34) begin
            cap.dest_ip = {frame_ff.dest_ip[23:0], b};
         end
         if (off >= {9'd0, trans}) begin
            rel = off - {9'd0, trans};
            if (rel < 16'd2) begin
               cap.source_port = {frame_ff.source_port[7:0], b};
            end else if (rel < 16'd4) begin
               cap.dest_port = {frame_ff.dest_port[7:0], b};
            end else if (rel == 16'd13) begin
               cap.flags = b;
            end
            if (rel == 16'd0) begin
               cap.sub_type = {8'd0, b};
            end
         end
      end else if (frame_ff.ether_kind == TYPE_ARP) begin
         if (off == 16'd20 || off == 16'd21) begin
            cap.sub_type = {frame_ff.sub_type[7:0], b};
         end
         if (off >= 16'd28 && off < 16'd32) begin
            cap.source_ip = {frame_ff.source_ip[23:0], b};
         end
         if (off >= 16'd38 && off < ARP_MIN_LEN) begin
            cap.dest_ip = {frame_ff.dest_ip[23:0], b};
         end
      end
      cap.byte_offset = (off != OFFSET_MAX) ? off + 16'd1 : off;
   end

   always_comb begin
      frame_in = frame_ff;
      if (advance) begin
         frame_in = s1_last_ff ? '0 : cap;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_ff <= '0;
      end else begin
         frame_ff <= frame_in;
      end
   end

   assign done.load  = advance && s1_last_ff;
   assign done.frame = cap;

   `EHC_ASSERT(a_clear_after_last, clock, reset, done.load |=> (frame_ff == '0),
      "frame state not cleared after a last beat")
   `EHC_ASSERT(a_accept_when_full, clock, reset,
      (accept && s1_valid_ff) |-> advance,
      "beat accepted over a held input beat")
   `EHC_ASSERT(a_offset_moves, clock, reset,
      (advance && !s1_last_ff) |=> (frame_ff.byte_offset != 16'd0),
      "byte offset did not advance on a middle beat")

endmodule

`default_nettype wire

// ----- rtl/ehc_result.sv -----
// -----------------------------------------------------------------------------
// Ethernet header classifier result stage
// Frame classification and the registered summary output.
// -----------------------------------------------------------------------------
`default_nettype none

`include "ethernet_header_classifier_defines.svh"

module ehc_result
   import ehc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic [15:0]   web_port,
   input  ehc_done_type  done,
   output logic          rsp_free,
   ehc_rsp_if.source     rsp_bus
);

   logic           rsp_valid_ff, rsp_valid_in;
   ehc_result_type res_ff, res_in;
   ehc_frame_type  f;

   assign f        = done.frame;
   assign rsp_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      res_in              = '0;
      res_in.frame_class  = CLASS_UNKNOWN;
      res_in.frame_length = f.byte_offset;
      if (f.byte_offset < ETH_HDR_LEN) begin
         res_in.frame_class = CLASS_MALFORMED;
      end else begin
         res_in.dest_mac   = f.dest_mac;
         res_in.source_mac = f.source_mac;
         if (f.ether_kind == TYPE_IPV4) begin
            res_in.source_ip = f.source_ip;
            res_in.dest_ip   = f.dest_ip;
            if (f.ip_protocol == PROTO_TCP) begin
               res_in.source_port   = f.source_port;
               res_in.dest_port     = f.dest_port;
               res_in.tcp_flag_bits = f.flags;
               res_in.frame_class   = (f.source_port == web_port || f.dest_port == web_port)
                                      ? CLASS_HTTP : CLASS_TCP;
            end else if (f.ip_protocol == PROTO_UDP) begin
               res_in.source_port = f.source_port;
               res_in.dest_port   = f.dest_port;
               res_in.frame_class = CLASS_UDP;
            end else if (f.ip_protocol == PROTO_ICMP) begin
               res_in.sub_type    = f.sub_type;
               res_in.frame_class = CLASS_ICMP;
            end else begin
               res_in.frame_class = CLASS_IPV4;
            end
         end else if (f.ether_kind == TYPE_ARP) begin
            if (f.byte_offset >= ARP_MIN_LEN) begin
               res_in.source_ip   = f.source_ip;
               res_in.dest_ip     = f.dest_ip;
               res_in.sub_type    = f.sub_type;
               res_in.frame_class = CLASS_ARP;
            end else begin
               res_in.frame_class = CLASS_ARP_SHORT;
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done.load) begin
         res_ff <= res_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.frame_class   = res_ff.frame_class;
   assign rsp_bus.frame_length  = res_ff.frame_length;
   assign rsp_bus.dest_mac      = res_ff.dest_mac;
   assign rsp_bus.source_mac    = res_ff.source_mac;
   assign rsp_bus.source_ip     = res_ff.source_ip;
   assign rsp_bus.dest_ip       = res_ff.dest_ip;
   assign rsp_bus.source_port   = res_ff.source_port;
   assign rsp_bus.dest_port     = res_ff.dest_port;
   assign rsp_bus.tcp_flag_bits = res_ff.tcp_flag_bits;
   assign rsp_bus.sub_type      = res_ff.sub_type;

   `EHC_ASSERT(a_load_has_room, clock, reset, done.load |-> rsp_free,
      "summary loaded over an untaken summary")
   `EHC_ASSERT(a_load_shows, clock, reset, done.load |=> rsp_valid_ff,
      "loaded summary not presented")
   `EHC_ASSERT(a_flags_tcp_only, clock, reset,
      (rsp_valid_ff && res_ff.frame_class != CLASS_TCP && res_ff.frame_class != CLASS_HTTP)
      |-> (res_ff.tcp_flag_bits == 8'd0),
      "TCP flags reported for a non-TCP frame")

endmodule

`default_nettype wire

// ----- rtl/ethernet_header_classifier.sv -----
// After a frame's last beat is accepted, its summary is loaded from the input beat
// register into the summary register. Throughput: one byte beat per cycle; the input
// register and the summary register let bytes keep flowing while a summary waits, and
// a last beat stalls only while the previous summary is still untaken. Reset clears the
// frame state, both valid bits and sets web_port to 80.
// -----------------------------------------------------------------------------
// Ethernet header classifier top level
// Parses Ethernet, IPv4 and ARP headers from a byte stream into a frame summary.
// -----------------------------------------------------------------------------
`default_nettype none

module ethernet_header_classifier
   import ehc_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   ehc_req_if.sink   req_bus,
   ehc_rsp_if.source rsp_bus,
   ehc_csr_if.sink   csr_bus
);

   logic [15:0]  web_port_ff, web_port_in;
   logic         rsp_free;
   ehc_done_type done;

   assign csr_bus.ready = 1'b1;
   assign web_port_in   = csr_bus.valid ? csr_bus.web_port : web_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         web_port_ff <= WEB_PORT_RESET;
      end else begin
         web_port_ff <= web_port_in;
      end
   end

   ehc_capture u_capture (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .rsp_free (rsp_free),
      .done     (done)
   );

   ehc_result u_result (
      .clock    (clock),
      .reset    (reset),
      .web_port (web_port_ff),
      .done     (done),
      .rsp_free (rsp_free),
      .rsp_bus  (rsp_bus)
   );

endmodule

`default_nettype wire

// ----- tb/ehc_summary_checker.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Ethernet header classifier summary checker
// Watches the byte, summary and CSR channels, predicts the summary of every
// frame from the accepted bytes, and compares each accepted summary with the
// oldest prediction.
// -----------------------------------------------------------------------------

module ehc_summary_checker
   import ehc_pkg::*;
(
   input  logic clock,
   input  logic reset,
   ehc_req_if   req_bus,
   ehc_rsp_if   rsp_bus,
   ehc_csr_if   csr_bus,
   output int   mismatch_count,
   output int   pending_count
);

   logic [15:0] web_port;
   logic [15:0] pos;
   logic [15:0] kind;
   logic [3:0]  hdr_words;
   logic [7:0]  proto;
   logic [47:0] dmac;
   logic [47:0] smac;
   logic [31:0] sip;
   logic [31:0] dip;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [7:0]  flags;
   logic [15:0] subtype;

   ehc_result_type expected_summaries[$];

   function automatic void clear_frame();
      pos = '0;
      kind = '0;
      hdr_words = '0;
      proto = '0;
      dmac = '0;
      smac = '0;
      sip = '0;
      dip = '0;
      sport = '0;
      dport = '0;
      flags = '0;
      subtype = '0;
   endfunction

   // Captures one byte at the current offset and, on the last beat of a frame,
   // queues the summary that the frame should produce.
   function automatic void absorb_byte(input logic [7:0] b, input logic last);
      ehc_result_type summary;
      logic [3:0]     words;
      logic [15:0]    flen;
      int             trans;
      int             rel;

      if (pos < 6) begin
         dmac = {dmac[39:0], b};
      end else if (pos < 12) begin
         smac = {smac[39:0], b};
      end else if (pos < 14) begin
         kind = {kind[7:0], b};
      end else if (kind == TYPE_IPV4) begin
         // The header length byte itself decides where the transport header starts.
         words = (pos == 14) ? b[3:0] : hdr_words;
         trans = 14 + words * 4;
         if (pos == 14) hdr_words = b[3:0];
         if (pos == 23) proto = b;
         if (pos >= 26 && pos < 30) sip = {sip[23:0], b};
         if (pos >= 30 && pos < 34) dip = {dip[23:0], b};
         if (pos >= trans) begin
            rel = pos - trans;
            if (rel < 2) sport = {sport[7:0], b};
            else if (rel < 4) dport = {dport[7:0], b};
            else if (rel == 13) flags = b;
            if (rel == 0) subtype = {8'h00, b};
         end
      end else if (kind == TYPE_ARP) begin
         if (pos == 20 || pos == 21) subtype = {subtype[7:0], b};
         if (pos >= 28 && pos < 32) sip = {sip[23:0], b};
         if (pos >= 38 && pos < 42) dip = {dip[23:0], b};
      end

      flen = (pos < OFFSET_MAX) ? pos + 16'd1 : OFFSET_MAX;
      if (pos < OFFSET_MAX) pos = pos + 16'd1;

      if (last) begin
         summary = '0;
         summary.frame_length = flen;
         summary.frame_class = CLASS_UNKNOWN;
         if (flen < ETH_HDR_LEN) begin
            summary.frame_class = CLASS_MALFORMED;
         end else begin
            summary.dest_mac = dmac;
            summary.source_mac = smac;
            if (kind == TYPE_IPV4) begin
               summary.source_ip = sip;
               summary.dest_ip = dip;
               if (proto == PROTO_TCP) begin
                  summary.source_port = sport;
                  summary.dest_port = dport;
                  summary.tcp_flag_bits = flags;
                  summary.frame_class = (sport == web_port || dport == web_port) ?
                                        CLASS_HTTP : CLASS_TCP;
               end else if (proto == PROTO_UDP) begin
                  summary.source_port = sport;
                  summary.dest_port = dport;
                  summary.frame_class = CLASS_UDP;
               end else if (proto == PROTO_ICMP) begin
                  summary.sub_type = subtype;
                  summary.frame_class = CLASS_ICMP;
               end else begin
                  summary.frame_class = CLASS_IPV4;
               end
            end else if (kind == TYPE_ARP) begin
               if (flen >= ARP_MIN_LEN) begin
                  summary.source_ip = sip;
                  summary.dest_ip = dip;
                  summary.sub_type = subtype;
                  summary.frame_class = CLASS_ARP;
               end else begin
                  summary.frame_class = CLASS_ARP_SHORT;
               end
            end
         end
         expected_summaries.push_back(summary);
         clear_frame();
      end
   endfunction

   function automatic void check_summary();
      ehc_result_type want;
      logic           bad;

      if (expected_summaries.size() == 0) begin
         if (mismatch_count < 10)
            $display("ehc_summary_checker: summary beat with nothing expected, class %0d len %0d",
                     rsp_bus.frame_class, rsp_bus.frame_length);
         mismatch_count++;
         return;
      end
      want = expected_summaries.pop_front();
      bad = (rsp_bus.frame_class !== want.frame_class) ||
            (rsp_bus.frame_length !== want.frame_length) ||
            (rsp_bus.dest_mac !== want.dest_mac) ||
            (rsp_bus.source_mac !== want.source_mac) ||
            (rsp_bus.source_ip !== want.source_ip) ||
            (rsp_bus.dest_ip !== want.dest_ip) ||
            (rsp_bus.source_port !== want.source_port) ||
            (rsp_bus.dest_port !== want.dest_port) ||
            (rsp_bus.tcp_flag_bits !== want.tcp_flag_bits) ||
            (rsp_bus.sub_type !== want.sub_type);
      if (bad) begin
         if (mismatch_count < 10) begin
            $display("ehc_summary_checker: expected class %0d len %0d mac %h %h ip %h %h port %h %h flags %h sub %h",
                     want.frame_class, want.frame_length, want.dest_mac, want.source_mac,
                     want.source_ip, want.dest_ip, want.source_port, want.dest_port,
                     want.tcp_flag_bits, want.sub_type);
            $display("ehc_summary_checker: actual   class %0d len %0d mac %h %h ip %h %h port %h %h flags %h sub %h",
                     rsp_bus.frame_class, rsp_bus.frame_length, rsp_bus.dest_mac,
                     rsp_bus.source_mac, rsp_bus.source_ip, rsp_bus.dest_ip,
                     rsp_bus.source_port, rsp_bus.dest_port, rsp_bus.tcp_flag_bits,
                     rsp_bus.sub_type);
         end
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_frame();
         web_port = WEB_PORT_RESET;
         expected_summaries.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) check_summary();
         if (csr_bus.valid && csr_bus.ready) web_port = csr_bus.web_port;
         if (req_bus.valid && req_bus.ready) absorb_byte(req_bus.data_byte, req_bus.last_byte);
      end
      pending_count = expected_summaries.size();
   end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Ethernet header classifier testbench
// Feeds directed and random frames byte by byte with random gaps and summary
// stalls, changes the web port between phases, and reports the verdict from
// the summary checker.
// -----------------------------------------------------------------------------

module tb_top;
   import ehc_pkg::*;

   typedef logic [7:0] byte_q_type[$];

   logic        clock;
   logic        reset;
   int          sender_idle_max;
   int          receiver_idle_max;
   int          rsp_hold_cycles;
   int          bytes_sent;
   int          frames_sent;
   int          mismatch_count;
   int          pending_count;
   logic [15:0] web_port_now;

   ehc_req_if req_if();
   ehc_rsp_if rsp_if();
   ehc_csr_if csr_if();

   ethernet_header_classifier dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   ehc_summary_checker summary_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_if),
      .rsp_bus        (rsp_if),
      .csr_bus        (csr_if),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   initial begin
      #2000000;
      $display("tb_top: FAIL");
      $finish;
   end

   // Summary receiver: a random stall after every beat, plus a long hold-off
   // when the stimulus asks for one.
   initial begin
      int idle_left;
      int hold_left;
      idle_left = 0;
      hold_left = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            hold_left = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (idle_left > 0) begin
            idle_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
         end
         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) idle_left = $urandom_range(0, receiver_idle_max);
      end
   end

   function automatic void poke(ref byte_q_type f, input int off, input logic [47:0] val,
                                input int nbytes);
      for (int i = 0; i < nbytes; i++)
         if (off + i < f.size()) f[off + i] = val[8 * (nbytes - 1 - i) +: 8];
   endfunction

   function automatic logic [15:0] pick_port();
      if ($urandom_range(0, 3) == 0) return web_port_now;
      return 16'($urandom);
   endfunction

   // Random bytes of the given length with the EtherType and, for IPv4, the
   // header length, protocol and ports placed where the frame reaches them.
   function automatic void build_frame(ref byte_q_type f, input int len,
                                       input logic [15:0] kind,
                                       input logic [3:0] ihl, input logic [7:0] proto);
      int trans;
      f.delete();
      repeat (len) f.push_back(8'($urandom));
      poke(f, 12, 48'(kind), 2);
      if (kind == TYPE_IPV4) begin
         trans = 14 + 4 * ihl;
         poke(f, 14, 48'({4'($urandom), ihl}), 1);
         poke(f, 23, 48'(proto), 1);
         poke(f, trans, 48'(pick_port()), 2);
         poke(f, trans + 2, 48'(pick_port()), 2);
      end
   endfunction

   function automatic void make_random_frame(ref byte_q_type f);
      int          pick;
      int          len;
      int          trans;
      logic [3:0]  ihl;
      logic [7:0]  proto;
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
         build_frame(f, $urandom_range(1, 13), 16'($urandom), 4'd0, 8'd0);
      end else if (pick < 16) begin
         build_frame(f, $urandom_range(14, 80), 16'($urandom), 4'd0, 8'd0);
      end else if (pick < 28) begin
         len = ($urandom_range(0, 2) == 0) ? $urandom_range(14, 41) : $urandom_range(42, 64);
         build_frame(f, len, TYPE_ARP, 4'd0, 8'd0);
      end else begin
         ihl = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
         case ($urandom_range(0, 6))
            0:       proto = PROTO_ICMP;
            1, 2, 3: proto = PROTO_TCP;
            4, 5:    proto = PROTO_UDP;
            default: proto = 8'($urandom);
         endcase
         trans = 14 + 4 * ihl;
         len = ($urandom_range(0, 3) == 0) ? $urandom_range(14, trans + 20) :
               trans + 20 + $urandom_range(0, 16);
         build_frame(f, len, TYPE_IPV4, ihl, proto);
      end
   endfunction

   // Every call drives the channel at the next falling edge, so a beat that
   // was just accepted is never offered twice.
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = $urandom_range(0, sender_idle_max);
      repeat (gap) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
      end
      @(negedge clock);
      req_if.valid <= 1'b1;
      req_if.data_byte <= b;
      req_if.last_byte <= last;
      do @(posedge clock); while (!req_if.ready);
      bytes_sent++;
   endtask

   task automatic send_frame(ref byte_q_type f);
      foreach (f[i]) send_byte(f[i], i == f.size() - 1);
      frames_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_web_port(input logic [15:0] port);
      csr_if.valid <= 1'b1;
      csr_if.web_port <= port;
      do @(posedge clock); while (!csr_if.ready);
      @(negedge clock);
      csr_if.valid <= 1'b0;
      web_port_now = port;
   endtask

   task automatic run_random_phase(input int min_bytes, input int min_frames,
                                   input int send_max, input int take_max);
      byte_q_type f;
      int         start_bytes;
      int         start_frames;
      start_bytes = bytes_sent;
      start_frames = frames_sent;
      while (bytes_sent - start_bytes < min_bytes || frames_sent - start_frames < min_frames) begin
         if ($urandom_range(0, 5) == 0) begin
            sender_idle_max = 0;
            receiver_idle_max = 0;
         end else begin
            sender_idle_max = send_max;
            receiver_idle_max = take_max;
         end
         make_random_frame(f);
         send_frame(f);
      end
   endtask

   initial begin
      byte_q_type f;
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.data_byte = '0;
      req_if.last_byte = 1'b0;
      csr_if.valid = 1'b0;
      csr_if.web_port = '0;
      sender_idle_max = 3;
      receiver_idle_max = 3;
      rsp_hold_cycles = 0;
      bytes_sent = 0;
      frames_sent = 0;
      web_port_now = WEB_PORT_RESET;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Runt frames: a single byte and one byte short of a full Ethernet header.
      build_frame(f, 1, 16'h0000, 4'd0, 8'd0);
      f[0] = 8'hFF;
      send_frame(f);
      build_frame(f, 13, 16'h0000, 4'd0, 8'd0);
      send_frame(f);

      // Unknown EtherTypes with the address extremes.
      build_frame(f, 14, 16'hFFFF, 4'd0, 8'd0);
      poke(f, 0, 48'hFFFF_FFFF_FFFF, 6);
      poke(f, 6, 48'h0, 6);
      send_frame(f);
      build_frame(f, 20, 16'h0000, 4'd0, 8'd0);
      poke(f, 0, 48'h0, 6);
      poke(f, 6, 48'hFFFF_FFFF_FFFF, 6);
      send_frame(f);

      // TCP on the web port as destination, then as source, then on neither.
      build_frame(f, 48, TYPE_IPV4, 4'd5, PROTO_TCP);
      poke(f, 34, 48'd1234, 2);
      poke(f, 36, 48'd80, 2);
      poke(f, 47, 48'hFF, 1);
      send_frame(f);
      build_frame(f, 48, TYPE_IPV4, 4'd5, PROTO_TCP);
      poke(f, 34, 48'd80, 2);
      poke(f, 36, 48'hFFFF, 2);
      send_frame(f);
      build_frame(f, 48, TYPE_IPV4, 4'd5, PROTO_TCP);
      poke(f, 34, 48'hFFFF, 2);
      poke(f, 36, 48'h0000, 2);
      poke(f, 47, 48'h00, 1);
      send_frame(f);

      build_frame(f, 38, TYPE_IPV4, 4'd5, PROTO_UDP);
      send_frame(f);
      build_frame(f, 38, TYPE_IPV4, 4'd5, PROTO_ICMP);
      send_frame(f);
      build_frame(f, 38, TYPE_IPV4, 4'd5, 8'hFF);
      send_frame(f);

      // ARP at the minimum full length, one byte short of it, and header only.
      build_frame(f, 42, TYPE_ARP, 4'd0, 8'd0);
      send_frame(f);
      build_frame(f, 41, TYPE_ARP, 4'd0, 8'd0);
      send_frame(f);
      build_frame(f, 14, TYPE_ARP, 4'd0, 8'd0);
      send_frame(f);

      // Header length of zero puts the transport header on the length byte;
      // the longest header runs past a truncated frame.
      build_frame(f, 28, TYPE_IPV4, 4'd0, PROTO_TCP);
      send_frame(f);
      build_frame(f, 28, TYPE_IPV4, 4'd0, PROTO_ICMP);
      send_frame(f);
      build_frame(f, 60, TYPE_IPV4, 4'd15, PROTO_TCP);
      send_frame(f);
      build_frame(f, 20, TYPE_IPV4, 4'd5, PROTO_UDP);
      send_frame(f);
      build_frame(f, 14, TYPE_IPV4, 4'd5, PROTO_TCP);
      send_frame(f);

      drain();
      run_random_phase(20, 1, 3, 3);

      drain();
      write_web_port(16'd0);
      // Hold the summary side off while runt frames keep coming, so that the
      // summary stages fill and the byte input stalls on a last beat.
      @(posedge clock);
      rsp_hold_cycles = 150;
      sender_idle_max = 0;
      repeat (12) begin
         build_frame(f, $urandom_range(1, 3), 16'h0000, 4'd0, 8'd0);
         send_frame(f);
      end
      run_random_phase(20, 1, 0, 3);

      drain();
      write_web_port(16'hFFFF);
      run_random_phase(20, 1, 3, 0);

      drain();
      write_web_port(16'($urandom));
      run_random_phase(20, 1, 0, 0);

      drain();
      write_web_port(16'd443);
      run_random_phase(20, 1, 3, 3);

      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (pending_count == 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
